// ===== rtl/dpmp_pkg.sv =====
// Shared types, codes and microcode ROM for the debug port message parser.
// Used by dpmp_useq and debug_port_message_parser_unit.
package dpmp_pkg;

    // Default sizes
    localparam int STRING_BYTES_DEF = 64;
    localparam int MAX_ENTRIES_DEF  = 32;
    localparam int ENTRY_WORDS      = 5;

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 208;

    // Magic words
    localparam logic [31:0] MAGIC_RECORD  = 32'hdeadeaaa;
    localparam logic [31:0] MAGIC_STRING  = 32'h5f535452;
    localparam logic [31:0] MAGIC_REC_END = 32'hdeadca5e;
    localparam logic [31:0] MAGIC_STR_END = 32'h5f454e44;
    localparam logic [31:0] READ_VALUE    = 32'hdead5555;

    // Bus actions
    localparam logic [1:0] ACT_WORD = 2'd0;
    localparam logic [1:0] ACT_BYTE = 2'd1;

    // Port modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_WAIT_NUM  = 3'd1;
    localparam logic [2:0] MODE_WAIT_DATA = 3'd2;
    localparam logic [2:0] MODE_WAIT_END  = 3'd3;
    localparam logic [2:0] MODE_STRING    = 3'd4;

    // Result kinds
    localparam logic [2:0] K_ACCEPT = 3'd0;
    localparam logic [2:0] K_POST   = 3'd1;
    localparam logic [2:0] K_ENTRY  = 3'd2;
    localparam logic [2:0] K_BYTE   = 3'd3;
    localparam logic [2:0] K_EMPTY  = 3'd4;
    localparam logic [2:0] K_READ   = 3'd5;
    localparam logic [2:0] K_ERROR  = 3'd6;

    // Error codes
    localparam logic [2:0] E_NONE       = 3'd0;
    localparam logic [2:0] E_BAD_OFFSET = 3'd1;
    localparam logic [2:0] E_STRAY_BYTE = 3'd2;
    localparam logic [2:0] E_STR_OVFL   = 3'd3;
    localparam logic [2:0] E_COUNT_BIG  = 3'd4;
    localparam logic [2:0] E_BAD_MARKER = 3'd5;

    // Sequencer next-address control
    localparam logic [1:0] SEQ_NEXT = 2'd0;
    localparam logic [1:0] SEQ_JUMP = 2'd1;
    localparam logic [1:0] SEQ_DISP = 2'd2;
    localparam logic [1:0] SEQ_LOOP = 2'd3;

    // Result value source
    localparam logic [1:0] VS_ZERO = 2'd0;
    localparam logic [1:0] VS_DATA = 2'd1;
    localparam logic [1:0] VS_READ = 2'd2;
    localparam logic [1:0] VS_BYTE = 2'd3;

    // Datapath operations
    localparam logic [2:0] OP_NONE     = 3'd0;
    localparam logic [2:0] OP_STR_CLR  = 3'd1;
    localparam logic [2:0] OP_STR_WR   = 3'd2;
    localparam logic [2:0] OP_CNT_LOAD = 3'd3;
    localparam logic [2:0] OP_WORD_WR  = 3'd4;

    typedef logic [4:0] uaddr_t;

    // Microcode addresses; the handler entry points double as dispatch codes
    localparam uaddr_t UA_FETCH     = 5'd0;
    localparam uaddr_t UA_DISP      = 5'd1;
    localparam uaddr_t UA_READ      = 5'd2;
    localparam uaddr_t UA_BAD_OFS   = 5'd3;
    localparam uaddr_t UA_STRAY     = 5'd4;
    localparam uaddr_t UA_FULL      = 5'd5;
    localparam uaddr_t UA_BYTE_OK   = 5'd6;
    localparam uaddr_t UA_OPEN_REC  = 5'd7;
    localparam uaddr_t UA_OPEN_STR  = 5'd8;
    localparam uaddr_t UA_POST      = 5'd9;
    localparam uaddr_t UA_NUM_BIG   = 5'd10;
    localparam uaddr_t UA_NUM_ZERO  = 5'd11;
    localparam uaddr_t UA_NUM_OK    = 5'd12;
    localparam uaddr_t UA_DATA      = 5'd13;
    localparam uaddr_t UA_DATA_LAST = 5'd14;
    localparam uaddr_t UA_BAD_MARK  = 5'd15;
    localparam uaddr_t UA_EMPTY     = 5'd16;
    localparam uaddr_t UA_ENT_DUMP  = 5'd17;
    localparam uaddr_t UA_STR_DUMP  = 5'd18;

    typedef struct packed {
        logic [1:0] seq;
        uaddr_t     target;
        logic       take;
        logic       emit;
        logic [2:0] kind;
        logic [2:0] err;
        logic [1:0] vsel;
        logic       ent;
        logic       mode_we;
        logic [2:0] mode_val;
        logic [2:0] op;
    } ucode_t;

    // Sequencer status in, control out
    typedef struct packed {
        logic   in_valid;
        logic   out_free;
        logic   at_end;
        uaddr_t entry;
    } useq_stat_t;

    typedef struct packed {
        ucode_t cw;
        logic   fire;
    } useq_ctrl_t;

    function automatic ucode_t uc(
        input logic [1:0] seq,
        input uaddr_t     target,
        input logic       take,
        input logic       emit,
        input logic [2:0] kind,
        input logic [2:0] err,
        input logic [1:0] vsel,
        input logic       ent,
        input logic       mode_we,
        input logic [2:0] mode_val,
        input logic [2:0] op
    );
        ucode_t w;
        w.seq      = seq;
        w.target   = target;
        w.take     = take;
        w.emit     = emit;
        w.kind     = kind;
        w.err      = err;
        w.vsel     = vsel;
        w.ent      = ent;
        w.mode_we  = mode_we;
        w.mode_val = mode_val;
        w.op       = op;
        return w;
    endfunction

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input uaddr_t a);
        ucode_t w;
        unique case (a)
            UA_FETCH:     w = uc(SEQ_NEXT, UA_FETCH, 1'b1, 1'b0, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b0, MODE_IDLE, OP_NONE);
            UA_DISP:      w = uc(SEQ_DISP, UA_FETCH, 1'b0, 1'b0, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b0, MODE_IDLE, OP_NONE);
            UA_READ:      w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_READ, E_NONE,
                                 VS_READ, 1'b0, 1'b0, MODE_IDLE, OP_NONE);
            UA_BAD_OFS:   w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ERROR, E_BAD_OFFSET,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_STRAY:     w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ERROR, E_STRAY_BYTE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_FULL:      w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ERROR, E_STR_OVFL,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_BYTE_OK:   w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b0, MODE_IDLE, OP_STR_WR);
            UA_OPEN_REC:  w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_WAIT_NUM, OP_NONE);
            UA_OPEN_STR:  w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_STRING, OP_STR_CLR);
            UA_POST:      w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_POST, E_NONE,
                                 VS_DATA, 1'b0, 1'b0, MODE_IDLE, OP_NONE);
            UA_NUM_BIG:   w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ERROR, E_COUNT_BIG,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_NUM_ZERO:  w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_WAIT_END, OP_CNT_LOAD);
            UA_NUM_OK:    w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_WAIT_DATA, OP_CNT_LOAD);
            UA_DATA:      w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b0, MODE_IDLE, OP_WORD_WR);
            UA_DATA_LAST: w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_WAIT_END, OP_WORD_WR);
            UA_BAD_MARK:  w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_ERROR, E_BAD_MARKER,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_EMPTY:     w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b1, K_EMPTY, E_NONE,
                                 VS_ZERO, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            UA_ENT_DUMP:  w = uc(SEQ_LOOP, UA_FETCH, 1'b0, 1'b1, K_ENTRY, E_NONE,
                                 VS_ZERO, 1'b1, 1'b1, MODE_IDLE, OP_NONE);
            UA_STR_DUMP:  w = uc(SEQ_LOOP, UA_FETCH, 1'b0, 1'b1, K_BYTE, E_NONE,
                                 VS_BYTE, 1'b0, 1'b1, MODE_IDLE, OP_NONE);
            default:      w = uc(SEQ_JUMP, UA_FETCH, 1'b0, 1'b0, K_ACCEPT, E_NONE,
                                 VS_ZERO, 1'b0, 1'b0, MODE_IDLE, OP_NONE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/debug_port_message_parser_unit.sv =====
// Top level of the debug port message parser: input latch, dispatch decode,
// string and entry stores, output register. Depends on dpmp_pkg, dpmp_ram, dpmp_useq.
//
//  Channel  | Signals                            | Payload
//  ---------+------------------------------------+---------------------------------------
//  s_axis   | tvalid tready tdata[39:0] tuser    | tuser: action; tdata: offset, data
//  m_axis   | tvalid tready tdata[207:0] tuser   | tuser: kind; tlast: last; tdata: error,
//           | tlast                              |   value, entry_index, word_a..word_e
//
// An item passes through three microcode steps (accept, dispatch, result); the step
// counter sets them. A dump repeats the result step for each result after the first,
// reading one store row per cycle while the output is free. Reset is asynchronous; the
// stores need no clearing pass. A stalled output holds the sequencer in its result step.
module debug_port_message_parser_unit
    import dpmp_pkg::*;
#(
    parameter int STRING_BYTES = STRING_BYTES_DEF,
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [2:0] offset, [34:3] data, [39:35] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [2:0] error_code, [34:3] value, [40:35] entry_index, [72:41] word_a,
    // [104:73] word_b, [136:105] word_c, [168:137] word_d, [200:169] word_e,
    // [207:201] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] kind
    output logic [2:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int SA_W = (STRING_BYTES > 1) ? $clog2(STRING_BYTES) : 1;
    localparam int SL_W = $clog2(STRING_BYTES + 1);
    localparam int RW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (SA_W > RW) ? SA_W : RW;

    useq_stat_t stat;
    useq_ctrl_t ctrl;
    ucode_t     cw;
    logic       fire;

    // Input latch
    logic [1:0]  act_reg;
    logic [2:0]  ofs_reg;
    logic [31:0] data_reg;

    // Parser state
    logic [2:0]      mode_reg;
    logic [2:0]      mode_next;
    logic [SL_W-1:0] str_len_reg;
    logic [SL_W-1:0] str_len_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [RW-1:0]   row_reg;
    logic [RW-1:0]   row_next;
    logic [2:0]      lane_reg;
    logic [2:0]      lane_next;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   idx_next;

    // Store ports
    logic                 str_we;
    logic [7:0]           str_q;
    logic [31:0]          ent_q [ENTRY_WORDS];
    logic [ENTRY_WORDS-1:0] ent_we;

    // Output register
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [2:0]  out_err_reg;
    logic [31:0] out_val_reg;
    logic [5:0]  out_idx_reg;
    logic [31:0] out_words_reg [ENTRY_WORDS];
    logic        out_last_reg;
    logic        out_load;

    logic        at_end;
    logic        last_word;
    uaddr_t      entry;
    logic [31:0] val_sel;

    dpmp_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign cw   = ctrl.cw;
    assign fire = ctrl.fire;

    assign s_axis_tready = cw.take;

    // Latch the input transaction
    always_ff @(posedge clk)
    begin
        if (cw.take && s_axis_tvalid)
        begin
            act_reg  <= s_axis_tuser;
            ofs_reg  <= s_axis_tdata[2:0];
            data_reg <= s_axis_tdata[34:3];
        end
    end

    // Last word of the last entry of a record
    assign last_word = (lane_reg == 3'(ENTRY_WORDS - 1))
                    && ((CW'(row_reg) + CW'(1)) == count_reg);

    // Decode the latched transaction into a handler entry point
    always_comb
    begin
        entry = UA_BAD_MARK;
        priority if (act_reg[1])
        begin
            entry = UA_READ;
        end
        else if (ofs_reg != 3'd0)
        begin
            entry = UA_BAD_OFS;
        end
        else if (act_reg == ACT_BYTE)
        begin
            priority if (mode_reg != MODE_STRING)
                entry = UA_STRAY;
            else if (str_len_reg >= SL_W'(STRING_BYTES))
                entry = UA_FULL;
            else
                entry = UA_BYTE_OK;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    priority if (data_reg == MAGIC_RECORD)
                        entry = UA_OPEN_REC;
                    else if (data_reg == MAGIC_STRING)
                        entry = UA_OPEN_STR;
                    else
                        entry = UA_POST;
                end
                MODE_WAIT_NUM:
                begin
                    priority if (data_reg > 32'(MAX_ENTRIES))
                        entry = UA_NUM_BIG;
                    else if (data_reg == 32'd0)
                        entry = UA_NUM_ZERO;
                    else
                        entry = UA_NUM_OK;
                end
                MODE_WAIT_DATA:
                begin
                    entry = last_word ? UA_DATA_LAST : UA_DATA;
                end
                MODE_WAIT_END:
                begin
                    priority if (data_reg != MAGIC_REC_END)
                        entry = UA_BAD_MARK;
                    else if (count_reg == CW'(0))
                        entry = UA_EMPTY;
                    else
                        entry = UA_ENT_DUMP;
                end
                MODE_STRING:
                begin
                    priority if (data_reg != MAGIC_STR_END)
                        entry = UA_BAD_MARK;
                    else if (str_len_reg == SL_W'(0))
                        entry = UA_EMPTY;
                    else
                        entry = UA_STR_DUMP;
                end
                default:
                begin
                    entry = UA_BAD_MARK;
                end
            endcase
        end
    end

    // Dump loop ends at the last stored byte or entry
    assign at_end = (cw.vsel == VS_BYTE) ? ((SL_W'(idx_reg) + SL_W'(1)) == str_len_reg)
                                         : ((CW'(idx_reg) + CW'(1)) == count_reg);

    assign out_load = cw.emit && fire;

    assign stat.in_valid = s_axis_tvalid;
    assign stat.out_free = !out_valid_reg || m_axis_tready;
    assign stat.at_end   = at_end;
    assign stat.entry    = entry;

    // Advance the parser state on a completed step
    always_comb
    begin
        mode_next    = mode_reg;
        str_len_next = str_len_reg;
        count_next   = count_reg;
        row_next     = row_reg;
        lane_next    = lane_reg;
        idx_next     = idx_reg;
        str_we       = 1'b0;
        ent_we       = '0;
        if (fire)
        begin
            if (cw.mode_we)
            begin
                mode_next = cw.mode_val;
            end
            unique case (cw.op)
                OP_STR_CLR:
                begin
                    str_len_next = '0;
                end
                OP_STR_WR:
                begin
                    str_we       = 1'b1;
                    str_len_next = str_len_reg + SL_W'(1);
                end
                OP_CNT_LOAD:
                begin
                    count_next = data_reg[CW-1:0];
                    row_next   = '0;
                    lane_next  = '0;
                end
                OP_WORD_WR:
                begin
                    ent_we[lane_reg] = 1'b1;
                    if (lane_reg == 3'(ENTRY_WORDS - 1))
                    begin
                        lane_next = '0;
                        row_next  = row_reg + RW'(1);
                    end
                    else
                    begin
                        lane_next = lane_reg + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
            // Step the dump index, back to zero at the end of the loop
            if (cw.seq == SEQ_LOOP)
            begin
                idx_next = at_end ? '0 : idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            str_len_reg <= '0;
            count_reg   <= '0;
            row_reg     <= '0;
            lane_reg    <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            str_len_reg <= str_len_next;
            count_reg   <= count_next;
            row_reg     <= row_next;
            lane_reg    <= lane_next;
            idx_reg     <= idx_next;
        end
    end

    // String byte store, read ahead at the next dump index
    dpmp_ram #(
        .WIDTH (8),
        .DEPTH (STRING_BYTES)
    ) u_str_ram (
        .clk   (clk),
        .we    (str_we),
        .waddr (str_len_reg[SA_W-1:0]),
        .wdata (data_reg[7:0]),
        .raddr (idx_next[SA_W-1:0]),
        .rdata (str_q)
    );

    // Entry store, one RAM per word of an entry
    for (genvar l = 0; l < ENTRY_WORDS; l++)
    begin : g_lane
        dpmp_ram #(
            .WIDTH (32),
            .DEPTH (MAX_ENTRIES)
        ) u_ent_ram (
            .clk   (clk),
            .we    (ent_we[l]),
            .waddr (row_reg),
            .wdata (data_reg),
            .raddr (idx_next[RW-1:0]),
            .rdata (ent_q[l])
        );
    end

    // Select the result value
    always_comb
    begin
        unique case (cw.vsel)
            VS_ZERO: val_sel = '0;
            VS_DATA: val_sel = data_reg;
            VS_READ: val_sel = READ_VALUE;
            VS_BYTE: val_sel = {24'd0, str_q};
            default: val_sel = '0;
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= cw.kind;
            out_err_reg  <= cw.err;
            out_val_reg  <= val_sel;
            out_idx_reg  <= 6'(idx_reg);
            out_last_reg <= (cw.seq != SEQ_LOOP) || at_end;
            for (int w = 0; w < ENTRY_WORDS; w++)
            begin
                out_words_reg[w] <= cw.ent ? ent_q[w] : 32'd0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, out_words_reg[4], out_words_reg[3], out_words_reg[2],
                            out_words_reg[1], out_words_reg[0], out_idx_reg,
                            out_val_reg, out_err_reg};

endmodule

// ===== rtl/dpmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dpmp_useq.sv =====
// Microcode sequencer: step counter, control store and next-address logic.
// Depends on dpmp_pkg.
module dpmp_useq
    import dpmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  useq_stat_t stat,
    output useq_ctrl_t ctrl
);

    uaddr_t upc_reg;
    uaddr_t upc_next;
    ucode_t cw;
    logic   fire;

    // Fetch the control word of the current step
    assign cw = ucode_rom(upc_reg);

    // A step completes once its input and output handshakes can finish
    assign fire = (!cw.take || stat.in_valid) && (!cw.emit || stat.out_free);

    assign ctrl.cw   = cw;
    assign ctrl.fire = fire;

    // Select the next step
    always_comb
    begin
        upc_next = upc_reg;
        if (fire)
        begin
            unique case (cw.seq)
                SEQ_NEXT: upc_next = upc_reg + uaddr_t'(1);
                SEQ_JUMP: upc_next = cw.target;
                SEQ_DISP: upc_next = stat.entry;
                SEQ_LOOP: upc_next = stat.at_end ? cw.target : upc_reg;
                default:  upc_next = UA_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule
